// ===== sv/mrb_pkg.sv =====
// ----------------------------------------------------------------------------
// mrb_pkg
// Shared types, constants and helpers of the modal resonator bank.
// ----------------------------------------------------------------------------
package mrb_pkg;

  localparam int MAX_MODES  = 32;
  localparam int MODE_W     = 5;           // mode index bits
  localparam int MODE_CNT_W = 6;           // holds a mode count up to MAX_MODES
  localparam int NUM_COEF   = 9;
  localparam int COEF_DEPTH = MAX_MODES * NUM_COEF;
  localparam int COEF_AW    = 9;
  localparam int STATE_W    = 48;
  localparam int COEF_W     = 64;
  localparam int DIG_W      = 17;          // signed, one 16-bit digit plus sign bit
  localparam int PROD_W     = COEF_W + DIG_W;
  localparam int ACC_W      = 128;
  localparam int NACC       = 3;
  localparam int WIDE_W     = 96;

  // input kinds
  localparam logic [2:0] FUNC_FORCE = 3'd0;
  localparam logic [2:0] FUNC_STEP  = 3'd1;
  localparam logic [2:0] FUNC_LOAD  = 3'd2;
  localparam logic [2:0] FUNC_SETP  = 3'd3;
  localparam logic [2:0] FUNC_SETV  = 3'd4;

  // configuration register indexes
  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_IGS    = 1'b1;

  // coefficient slots
  localparam logic [3:0] CS_PP  = 4'd0;
  localparam logic [3:0] CS_PV  = 4'd1;
  localparam logic [3:0] CS_VP  = 4'd2;
  localparam logic [3:0] CS_VV  = 4'd3;
  localparam logic [3:0] CS_B1  = 4'd4;
  localparam logic [3:0] CS_B0V = 4'd5;
  localparam logic [3:0] CS_FS  = 4'd6;
  localparam logic [3:0] CS_CW  = 4'd7;
  localparam logic [3:0] CS_OW  = 4'd8;

  // sequencer jobs
  localparam logic [2:0] JOB_FORCE = 3'd0;
  localparam logic [2:0] JOB_STEP1 = 3'd1;
  localparam logic [2:0] JOB_STEP2 = 3'd2;
  localparam logic [2:0] JOB_SET   = 3'd3;
  localparam logic [2:0] JOB_SUM   = 3'd4;

  // multiplier operand sources
  localparam logic [2:0] BS_AMT = 3'd0;
  localparam logic [2:0] BS_F   = 3'd1;
  localparam logic [2:0] BS_P   = 3'd2;
  localparam logic [2:0] BS_V   = 3'd3;
  localparam logic [2:0] BS_DP  = 3'd4;

  localparam logic signed [WIDE_W-1:0] SAT_MAX   = 96'sh7FFF_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] SAT_MIN   = -96'sh8000_0000_0000;
  localparam logic signed [WIDE_W-1:0] POS_LIMIT = 96'sd42949672960000;

  typedef struct packed {
    logic [3:0] sel;
    logic [2:0] bsrc;
    logic [1:0] acc;
    logic       clr;
  } prod_desc_t;

  typedef struct packed {
    logic                     valid;
    logic                     clr;
    logic [1:0]               acc;
    logic [1:0]               dig_idx;
    logic signed [COEF_W-1:0] a;
    logic signed [DIG_W-1:0]  dig;
  } mac_op_t;

  typedef logic [NACC-1:0][ACC_W-1:0] acc_bank_t;

  function automatic prod_desc_t prod_desc(input logic [2:0] job, input logic [2:0] k);
    prod_desc_t r;
    r = '{sel: CS_PP, bsrc: BS_AMT, acc: 2'd0, clr: 1'b1};
    unique case (job)
      JOB_FORCE: r = '{sel: CS_FS, bsrc: BS_AMT, acc: 2'd0, clr: 1'b1};
      JOB_STEP1: r = '{sel: CS_B1, bsrc: BS_F, acc: 2'd0, clr: 1'b1};
      JOB_STEP2: begin
        unique case (k)
          3'd0:    r = '{sel: CS_PP, bsrc: BS_P, acc: 2'd0, clr: 1'b0};
          3'd1:    r = '{sel: CS_PV, bsrc: BS_V, acc: 2'd0, clr: 1'b0};
          3'd2:    r = '{sel: CS_VP, bsrc: BS_P, acc: 2'd1, clr: 1'b1};
          3'd3:    r = '{sel: CS_VV, bsrc: BS_V, acc: 2'd1, clr: 1'b0};
          default: r = '{sel: CS_B0V, bsrc: BS_DP, acc: 2'd1, clr: 1'b0};
        endcase
      end
      JOB_SET:   r = '{sel: CS_PP, bsrc: BS_AMT, acc: 2'd0, clr: 1'b1};
      default: begin
        unique case (k)
          3'd0:    r = '{sel: CS_CW, bsrc: BS_P, acc: 2'd0, clr: 1'b1};
          3'd1:    r = '{sel: CS_CW, bsrc: BS_V, acc: 2'd1, clr: 1'b1};
          default: r = '{sel: CS_OW, bsrc: BS_P, acc: 2'd2, clr: 1'b1};
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [2:0] prod_last(input logic [2:0] job);
    logic [2:0] r;
    unique case (job)
      JOB_STEP2: r = 3'd4;
      JOB_SUM:   r = 3'd2;
      default:   r = 3'd0;
    endcase
    return r;
  endfunction

  // round half up, Q.88 -> Q.32
  function automatic logic signed [WIDE_W-1:0] rnd56(input logic [ACC_W-1:0] x);
    logic [ACC_W-1:0] t;
    t = x + (128'd1 << 55);
    return {{24{t[ACC_W-1]}}, t[ACC_W-1:56]};
  endfunction

  // round half up, Q.64 -> Q.32
  function automatic logic signed [WIDE_W-1:0] rnd32(input logic [ACC_W-1:0] x);
    logic [ACC_W-1:0] t;
    t = x + (128'd1 << 31);
    return t[ACC_W-1:32];
  endfunction

  function automatic logic [STATE_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    if (v > SAT_MAX) r = SAT_MAX;
    else if (v < SAT_MIN) r = SAT_MIN;
    else r = v;
    return r[STATE_W-1:0];
  endfunction

  function automatic logic over_limit(input logic signed [WIDE_W-1:0] v);
    return (v >= POS_LIMIT) || (v <= -POS_LIMIT);
  endfunction

endpackage

// ===== sv/mrb_coef_mem.sv =====
// ----------------------------------------------------------------------------
// mrb_coef_mem
// Per-mode coefficient memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrb_coef_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [mrb_pkg::COEF_AW-1:0] waddr_i,
  input  logic [mrb_pkg::COEF_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [mrb_pkg::COEF_AW-1:0] raddr_i,
  output logic [mrb_pkg::COEF_W-1:0]  rdata_o
);

  logic [mrb_pkg::COEF_W-1:0] mem [mrb_pkg::COEF_DEPTH];
  logic [mrb_pkg::COEF_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mrb_mac.sv =====
// ----------------------------------------------------------------------------
// mrb_mac
// Shared multiply-accumulate unit: 64x17 signed digit product, registered,
// then shifted and added into one of three 128-bit accumulators.
// ----------------------------------------------------------------------------
module mrb_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mrb_pkg::mac_op_t    op_i,
  output mrb_pkg::acc_bank_t  acc_o
);

  logic                               v1_q;
  logic                               clr1_q;
  logic [1:0]                         acc1_q;
  logic [1:0]                         sh1_q;
  logic signed [mrb_pkg::PROD_W-1:0]  prod_q;
  mrb_pkg::acc_bank_t                 acc_q;
  logic [mrb_pkg::ACC_W-1:0]          addend;
  logic [mrb_pkg::ACC_W-1:0]          base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= op_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(op_i.a) * $signed(op_i.dig);
    clr1_q <= op_i.clr;
    acc1_q <= op_i.acc;
    sh1_q  <= op_i.dig_idx;
  end

  always_comb begin
    addend = {{(mrb_pkg::ACC_W - mrb_pkg::PROD_W){prod_q[mrb_pkg::PROD_W-1]}}, prod_q}
             << {sh1_q, 4'b0000};
    base   = clr1_q ? '0 : acc_q[acc1_q];
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      acc_q[acc1_q] <= base + addend;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== sv/modal_resonator_bank.sv =====
// ----------------------------------------------------------------------------
// modal_resonator_bank
// Bank of modal resonators sequenced through one shared multiply-accumulate.
// ----------------------------------------------------------------------------
//  channel  | direction | signals
//  s_axis   | in        | tvalid, tready, tdata (mode_index, coef_value, amount),
//           |           | tuser (func, coef_select)
//  m_axis   | out       | tvalid, tready, tdata (contact_position, contact_velocity,
//           |           | sound_out), tuser (limit_flag)
//  cfg      | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// Each product reads its coefficient (set uses the IGS register instead) and feeds four
// 16-bit digits to the shared multiplier; each group then drains and is written back.
// Per active mode force runs one product and step six; set runs one product, load none,
// and every item ends with a sum pass of three products per mode. After reset a clearing
// pass zeroes the coefficient memory; no item is taken meanwhile. One item is worked at
// a time; the result register lets the next item start while a result waits.
// ----------------------------------------------------------------------------
module modal_resonator_bank (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [119:0]  s_axis_tdata_i,   // mode_index, coef_value, amount
  input  logic [6:0]    s_axis_tuser_i,   // func, coef_select
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [143:0]  m_axis_tdata_o,   // contact_position, contact_velocity, sound_out
  output logic          m_axis_tuser_o,   // limit_flag
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [46:0]   cfg_wdata_i
);

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_FETCH  = 3'd2;
  localparam logic [2:0] ST_ISSUE  = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_POST   = 3'd5;
  localparam logic [2:0] ST_COMMIT = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  localparam int SW = mrb_pkg::STATE_W;

  logic [2:0]                        state_q;
  logic [2:0]                        job_q;
  logic [mrb_pkg::MODE_W-1:0]        m_q;
  logic [2:0]                        k_q;
  logic [1:0]                        d_q;
  logic                              err_q;
  logic                              zero_q;
  logic [mrb_pkg::COEF_AW-1:0]       clr_cnt_q;
  logic [2:0]                        func_q;
  logic [SW-1:0]                     amt_q;
  logic [63:0]                       dp_q;
  logic [5:0]                        am_q;
  logic [46:0]                       igs_q;

  logic [SW-1:0] pos_q [mrb_pkg::MAX_MODES];
  logic [SW-1:0] vel_q [mrb_pkg::MAX_MODES];
  logic [SW-1:0] pf_q  [mrb_pkg::MAX_MODES];
  logic [SW-1:0] np_q  [mrb_pkg::MAX_MODES];
  logic [SW-1:0] nv_q  [mrb_pkg::MAX_MODES];

  logic          out_valid_q;
  logic [143:0]  out_data_q;
  logic          out_err_q;

  // input unpacking
  logic [2:0]                      in_func;
  logic [3:0]                      in_sel;
  logic [mrb_pkg::MODE_W-1:0]      in_midx;
  logic [63:0]                     in_cval;
  logic [SW-1:0]                   in_amt;
  logic                            s_fire;

  logic [mrb_pkg::MODE_CNT_W-1:0]  n_w;
  logic                            m_last;
  mrb_pkg::prod_desc_t             desc;
  logic [63:0]                     bop;
  mrb_pkg::mac_op_t                op;
  mrb_pkg::acc_bank_t              acc;
  logic [63:0]                     coef_rdata;
  logic                            mem_we;
  logic [mrb_pkg::COEF_AW-1:0]     mem_waddr;
  logic [63:0]                     mem_wdata;
  logic [mrb_pkg::COEF_AW-1:0]     mem_raddr;
  logic                            load_ok;

  logic signed [mrb_pkg::WIDE_W-1:0] r0;
  logic signed [mrb_pkg::WIDE_W-1:0] r1;
  logic signed [mrb_pkg::WIDE_W-1:0] rs;

  assign in_func = s_axis_tuser_i[2:0];
  assign in_sel  = s_axis_tuser_i[6:3];
  assign in_midx = s_axis_tdata_i[4:0];
  assign in_cval = s_axis_tdata_i[68:5];
  assign in_amt  = s_axis_tdata_i[116:69];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign n_w    = (am_q > mrb_pkg::MODE_CNT_W'(mrb_pkg::MAX_MODES))
                  ? mrb_pkg::MODE_CNT_W'(mrb_pkg::MAX_MODES) : am_q;
  assign m_last = ({1'b0, m_q} == (n_w - 6'd1));
  assign desc   = mrb_pkg::prod_desc(job_q, k_q);

  assign load_ok = (in_sel < 4'(mrb_pkg::NUM_COEF))
                   && ({1'b0, in_midx} < mrb_pkg::MODE_CNT_W'(mrb_pkg::MAX_MODES));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = '0;
    if (state_q == ST_CLR) begin
      mem_we = 1'b1;
    end else if (s_fire && (in_func == mrb_pkg::FUNC_LOAD) && load_ok) begin
      mem_we    = 1'b1;
      mem_waddr = ({4'b0, in_midx} << 3) + {4'b0, in_midx} + {5'b0, in_sel};
      mem_wdata = in_cval;
    end
  end

  assign mem_raddr = ({4'b0, m_q} << 3) + {4'b0, m_q} + {5'b0, desc.sel};

  mrb_coef_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (state_q == ST_FETCH),
    .raddr_i (mem_raddr),
    .rdata_o (coef_rdata)
  );

  always_comb begin
    unique case (desc.bsrc)
      mrb_pkg::BS_F:  bop = {{16{pf_q[m_q][SW-1]}}, pf_q[m_q]};
      mrb_pkg::BS_P:  bop = {{16{pos_q[m_q][SW-1]}}, pos_q[m_q]};
      mrb_pkg::BS_V:  bop = {{16{vel_q[m_q][SW-1]}}, vel_q[m_q]};
      mrb_pkg::BS_DP: bop = dp_q;
      default:        bop = {{16{amt_q[SW-1]}}, amt_q};
    endcase
  end

  always_comb begin
    op.valid   = (state_q == ST_ISSUE);
    op.clr     = desc.clr && (d_q == 2'd0) && ((job_q != mrb_pkg::JOB_SUM) || (m_q == '0));
    op.acc     = desc.acc;
    op.dig_idx = d_q;
    op.a       = (job_q == mrb_pkg::JOB_SET) ? {17'b0, igs_q} : coef_rdata;
    unique case (d_q)
      2'd0:    op.dig = {1'b0, bop[15:0]};
      2'd1:    op.dig = {1'b0, bop[31:16]};
      2'd2:    op.dig = {1'b0, bop[47:32]};
      default: op.dig = {bop[63], bop[63:48]};
    endcase
  end

  mrb_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .acc_o  (acc)
  );

  assign r0 = mrb_pkg::rnd56(acc[0]);
  assign r1 = mrb_pkg::rnd56(acc[1]);
  assign rs = mrb_pkg::rnd32(acc[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin : seq
    logic to_sum;
    to_sum = 1'b0;
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_cnt_q   <= '0;
      job_q       <= mrb_pkg::JOB_SUM;
      m_q         <= '0;
      k_q         <= '0;
      d_q         <= '0;
      err_q       <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      am_q        <= 6'd32;
      igs_q       <= '0;
      for (int i = 0; i < mrb_pkg::MAX_MODES; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        pf_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == mrb_pkg::CFG_ACTIVE) am_q <= cfg_wdata_i[5:0];
        else igs_q <= cfg_wdata_i;
      end
      if (m_axis_tready_i && (state_q != ST_OUT)) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_CLR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == mrb_pkg::COEF_AW'(mrb_pkg::COEF_DEPTH - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_fire) begin
            func_q <= in_func;
            amt_q  <= in_amt;
            err_q  <= 1'b0;
            priority case (in_func)
              mrb_pkg::FUNC_FORCE:                    to_sum = (n_w == '0);
              mrb_pkg::FUNC_STEP:                     to_sum = (n_w == '0);
              mrb_pkg::FUNC_SETP, mrb_pkg::FUNC_SETV: to_sum = (igs_q == '0);
              default:                                to_sum = 1'b1;
            endcase
            if (!to_sum) begin
              m_q <= '0;
              k_q <= '0;
              d_q <= '0;
              unique case (in_func)
                mrb_pkg::FUNC_FORCE: begin
                  job_q   <= mrb_pkg::JOB_FORCE;
                  state_q <= ST_FETCH;
                end
                mrb_pkg::FUNC_STEP: begin
                  job_q   <= mrb_pkg::JOB_STEP1;
                  state_q <= ST_FETCH;
                end
                default: begin
                  job_q   <= mrb_pkg::JOB_SET;
                  state_q <= ST_ISSUE;
                end
              endcase
            end
          end
        end
        ST_FETCH: begin
          d_q     <= '0;
          state_q <= ST_ISSUE;
        end
        ST_ISSUE: begin
          d_q <= d_q + 2'd1;
          if (d_q == 2'd3) begin
            if (k_q == mrb_pkg::prod_last(job_q)) begin
              state_q <= ST_DRAIN;
            end else begin
              k_q     <= k_q + 3'd1;
              state_q <= ST_FETCH;
            end
          end
        end
        ST_DRAIN: state_q <= ST_POST;
        ST_POST: begin
          unique case (job_q)
            mrb_pkg::JOB_FORCE: begin
              pf_q[m_q] <= mrb_pkg::sat48($signed({{48{pf_q[m_q][SW-1]}}, pf_q[m_q]}) + r0);
              if (m_last) to_sum = 1'b1;
              else begin
                m_q     <= m_q + 1'b1;
                state_q <= ST_FETCH;
              end
            end
            mrb_pkg::JOB_STEP1: begin
              dp_q    <= r0[63:0];
              job_q   <= mrb_pkg::JOB_STEP2;
              state_q <= ST_FETCH;
            end
            mrb_pkg::JOB_STEP2: begin
              np_q[m_q] <= r0[SW-1:0];
              nv_q[m_q] <= mrb_pkg::sat48(r1);
              if (mrb_pkg::over_limit(r0)) begin
                err_q  <= 1'b1;
                to_sum = 1'b1;
              end else if (m_last) begin
                state_q <= ST_COMMIT;
              end else begin
                m_q     <= m_q + 1'b1;
                k_q     <= '0;
                job_q   <= mrb_pkg::JOB_STEP1;
                state_q <= ST_FETCH;
              end
            end
            mrb_pkg::JOB_SET: begin
              if (func_q == mrb_pkg::FUNC_SETP) begin
                if (mrb_pkg::over_limit(rs)) err_q <= 1'b1;
                else begin
                  for (int i = 0; i < mrb_pkg::MAX_MODES; i++) begin
                    if (mrb_pkg::MODE_CNT_W'(i) < n_w) pos_q[i] <= rs[SW-1:0];
                  end
                end
              end else begin
                for (int i = 0; i < mrb_pkg::MAX_MODES; i++) begin
                  if (mrb_pkg::MODE_CNT_W'(i) < n_w) vel_q[i] <= mrb_pkg::sat48(rs);
                end
              end
              to_sum = 1'b1;
            end
            default: begin
              if (m_last) state_q <= ST_OUT;
              else begin
                m_q     <= m_q + 1'b1;
                k_q     <= '0;
                state_q <= ST_FETCH;
              end
            end
          endcase
        end
        ST_COMMIT: begin
          for (int i = 0; i < mrb_pkg::MAX_MODES; i++) begin
            if (mrb_pkg::MODE_CNT_W'(i) < n_w) begin
              pos_q[i] <= np_q[i];
              vel_q[i] <= nv_q[i];
              pf_q[i]  <= '0;
            end
          end
          to_sum = 1'b1;
        end
        default: begin
          // result register frees as the previous result is taken
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_err_q   <= err_q;
            if (zero_q) out_data_q <= '0;
            else out_data_q <= {mrb_pkg::sat48(mrb_pkg::rnd56(acc[2])),
                                mrb_pkg::sat48(r1), mrb_pkg::sat48(r0)};
            state_q <= ST_IDLE;
          end
        end
      endcase

      if (to_sum) begin
        job_q   <= mrb_pkg::JOB_SUM;
        m_q     <= '0;
        k_q     <= '0;
        d_q     <= '0;
        zero_q  <= (n_w == '0);
        state_q <= (n_w == '0) ? ST_OUT : ST_FETCH;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_err_q;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q != ST_IDLE))
    else $error("block still idle after taking an item");

  a_mode_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_ISSUE) && (job_q != mrb_pkg::JOB_SET)) |-> ({1'b0, m_q} < n_w))
    else $error("sequencer mode index past active count");

  a_post_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POST) |-> ($past(state_q) == ST_DRAIN))
    else $error("writeback without accumulator drain");

  a_err_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_OUT) && err_q) |->
      ((func_q == mrb_pkg::FUNC_STEP) || (func_q == mrb_pkg::FUNC_SETP)))
    else $error("domain error on an item that cannot raise it");
`endif

endmodule
